@@ rtl/bis_pkg.sv @@
// Package for the bounded identifier set: sizes, the empty marker and request codes.
// Used by bounded_id_set_top; depends on nothing else.
package bis_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic [ID_W-1:0] EMPTY_MARK = {ID_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_DEL  = 2'd1,
        REQ_FIND = 2'd2,
        REQ_BAD  = 2'd3
    } t_req;

endpackage

@@ rtl/bounded_id_set_top.sv @@
// Bounded unordered identifier set with swap-with-last deletion; depends on bis_pkg.
// A request that needs no search goes straight to the response; a search that finds nothing scans
// every held entry, a match ends it at that slot, and a delete that moves the last adds S_RDLAST, S_MOVE.
// One request is handled at a time, the next taken in the same cycle as the result is presented;
// one read port sets this.
// Reset clears the count and handshake state only; entries beyond the count are never compared.
module bounded_id_set_top
    import bis_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_req_type,
    input  logic signed [ID_W-1:0] i_item_id,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_status,
    output logic                   o_found,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RDLAST,
        S_MOVE,
        S_RESP
    } t_state;

    logic [ID_W-1:0] mem [MAX_ENTRIES];
    logic [ID_W-1:0] r_rdata;

    t_state           r_state, n_state;
    t_req             r_op, n_op;
    logic [ID_W-1:0]  r_key, n_key;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_raddr, n_raddr;
    logic             r_dvalid, n_dvalid;
    logic [IDX_W-1:0] r_didx, n_didx;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic             r_res_status, n_res_status;
    logic             r_res_found, n_res_found;
    logic             r_out_valid, n_out_valid;
    logic             r_out_status, n_out_status;
    logic             r_out_found, n_out_found;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ID_W-1:0]  mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    logic             can_emit;
    logic             key_empty;
    logic             hit;
    logic [CNT_W-1:0] occ_m1;
    logic [IDX_W-1:0] last_idx;

    assign can_emit  = !r_out_valid || i_out_ready;
    assign key_empty = (i_item_id == EMPTY_MARK);
    assign hit       = r_dvalid && (r_rdata == r_key);
    assign occ_m1    = r_occ - 1'b1;
    assign last_idx  = occ_m1[IDX_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_occ        = r_occ;
        n_raddr      = r_raddr;
        n_dvalid     = r_dvalid;
        n_didx       = r_didx;
        n_pos        = r_pos;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_occ[IDX_W-1:0];
        mem_wdata    = r_key;
        mem_raddr    = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = t_req'(i_req_type);
                    n_key        = i_item_id;
                    n_res_status = 1'b0;
                    n_res_found  = 1'b0;
                    n_raddr      = CNT_W'(1);
                    n_didx       = '0;
                    n_dvalid     = 1'b0;
                    n_state      = S_RESP;
                    unique case (t_req'(i_req_type))
                        REQ_ADD: begin
                            if (key_empty || r_occ >= CNT_W'(MAX_ENTRIES)) begin
                                n_res_status = 1'b1;
                            end else if (r_occ == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_item_id;
                                n_occ     = CNT_W'(1);
                            end else begin
                                n_dvalid = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        REQ_DEL: begin
                            if (key_empty || r_occ == '0) begin
                                n_res_status = 1'b1;
                            end else begin
                                n_dvalid = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        REQ_FIND: begin
                            if (!key_empty && r_occ != '0) begin
                                n_dvalid = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            n_res_status = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Reads are issued one ahead of the compare, as read data is registered.
                mem_raddr = r_raddr[IDX_W-1:0];
                if (hit) begin
                    n_dvalid = 1'b0;
                    n_state  = S_RESP;
                    unique case (r_op)
                        REQ_ADD: begin
                            n_res_status = 1'b1;
                        end
                        REQ_DEL: begin
                            n_pos = r_didx;
                            if (r_didx == last_idx) begin
                                n_occ = occ_m1;
                            end else begin
                                n_state = S_RDLAST;
                            end
                        end
                        default: begin
                            n_res_found = 1'b1;
                        end
                    endcase
                end else if (r_dvalid) begin
                    if (r_raddr < r_occ) begin
                        n_dvalid = 1'b1;
                        n_didx   = r_raddr[IDX_W-1:0];
                        n_raddr  = CNT_W'(r_raddr + 1'b1);
                    end else begin
                        n_dvalid = 1'b0;
                    end
                end else begin
                    // Every held entry has been compared without a match.
                    n_state = S_RESP;
                    unique case (r_op)
                        REQ_ADD: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_occ[IDX_W-1:0];
                            mem_wdata = r_key;
                            n_occ     = CNT_W'(r_occ + 1'b1);
                        end
                        REQ_DEL: begin
                            n_res_status = 1'b1;
                        end
                        default: begin
                            n_res_found = 1'b0;
                        end
                    endcase
                end
            end

            S_RDLAST: begin
                mem_raddr = last_idx;
                n_state   = S_MOVE;
            end

            S_MOVE: begin
                // The last entry fills the hole left by the deleted identifier.
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_rdata;
                n_occ     = occ_m1;
                n_state   = S_RESP;
            end

            S_RESP: begin
                if (can_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                    n_out_count  = COUNT_OUT_W'(r_occ);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_raddr      <= n_raddr;
        r_didx       <= n_didx;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_dvalid    <= n_dvalid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_entry_count = r_out_count;

endmodule
